// ===== rtl/rfa_pkg.sv =====
// Shared types, codes and the microcode program of the rational fraction ALU.
package rfa_pkg;

    localparam int WIDTH = 32;
    localparam int ACT_W = 3;
    localparam int CLS_W = 3;
    localparam int PC_W  = 5;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SCALE    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLASSIFY = 3'd5;

    // Classification codes.
    localparam logic [CLS_W-1:0] CLS_SIMPLIFIABLE = 3'd0;
    localparam logic [CLS_W-1:0] CLS_INTEGER      = 3'd1;
    localparam logic [CLS_W-1:0] CLS_PROPER       = 3'd2;
    localparam logic [CLS_W-1:0] CLS_ZERO         = 3'd3;
    localparam logic [CLS_W-1:0] CLS_DIV_ZERO     = 3'd4;

    // Multiplier operand selects.
    localparam logic SEL_A_NUM = 1'b0;
    localparam logic SEL_A_DEN = 1'b1;
    localparam logic SEL_B_NUM = 1'b0;
    localparam logic SEL_B_DEN = 1'b1;

    // Datapath operations.
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_ACC_LD   = 4'd1;
    localparam logic [3:0] OP_NUM_LD   = 4'd2;
    localparam logic [3:0] OP_NUM_ADD  = 4'd3;
    localparam logic [3:0] OP_NUM_SUB  = 4'd4;
    localparam logic [3:0] OP_DEN_LD   = 4'd5;
    localparam logic [3:0] OP_CLR      = 4'd6;
    localparam logic [3:0] OP_GCD_INIT = 4'd7;
    localparam logic [3:0] OP_GCD_STEP = 4'd8;
    localparam logic [3:0] OP_CLS_SET  = 4'd9;

    // Sequencing modes.
    localparam logic [1:0] JMP_NEXT = 2'd0;
    localparam logic [1:0] JMP_WAIT = 2'd1;
    localparam logic [1:0] JMP_DONE = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic       a_sel;
        logic       b_sel;
        logic [3:0] op;
        logic [1:0] jmp;
    } ctrl_word_t;

    // Per-step control handed from the sequencer to the datapath.
    typedef struct packed {
        ctrl_word_t word;
        logic       step_en;
    } dp_ctrl_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic gcd_done;
    } dp_stat_t;

    // Program entry points.
    localparam logic [PC_W-1:0] PC_ADD      = 5'd0;
    localparam logic [PC_W-1:0] PC_SUB      = 5'd5;
    localparam logic [PC_W-1:0] PC_MUL      = 5'd10;
    localparam logic [PC_W-1:0] PC_DIV      = 5'd14;
    localparam logic [PC_W-1:0] PC_SCALE    = 5'd18;
    localparam logic [PC_W-1:0] PC_CLASSIFY = 5'd22;
    localparam logic [PC_W-1:0] PC_UNUSED   = 5'd26;

    function automatic ctrl_word_t uw(input logic mul_en, input logic a_sel,
                                      input logic b_sel, input logic [3:0] op,
                                      input logic [1:0] jmp);
        ctrl_word_t w;
        w.mul_en = mul_en;
        w.a_sel  = a_sel;
        w.b_sel  = b_sel;
        w.op     = op;
        w.jmp    = jmp;
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [ACT_W-1:0] act);
        logic [PC_W-1:0] pc;
        case (act)
            ACT_ADD:      pc = PC_ADD;
            ACT_SUB:      pc = PC_SUB;
            ACT_MUL:      pc = PC_MUL;
            ACT_DIV:      pc = PC_DIV;
            ACT_SCALE:    pc = PC_SCALE;
            ACT_CLASSIFY: pc = PC_CLASSIFY;
            default:      pc = PC_UNUSED;
        endcase
        return pc;
    endfunction

    // Each step that reads the product register gets the product selected by the step before it.
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            // add: (an*bd + ad*bn) / (ad*bd)
            5'd0:  w = uw(1'b1, SEL_A_NUM, SEL_B_DEN, OP_NOP,      JMP_NEXT);
            5'd1:  w = uw(1'b1, SEL_A_DEN, SEL_B_NUM, OP_ACC_LD,   JMP_NEXT);
            5'd2:  w = uw(1'b1, SEL_A_DEN, SEL_B_DEN, OP_NUM_ADD,  JMP_NEXT);
            5'd3:  w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_DEN_LD,   JMP_NEXT);
            5'd4:  w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_DONE);
            // subtract
            5'd5:  w = uw(1'b1, SEL_A_NUM, SEL_B_DEN, OP_NOP,      JMP_NEXT);
            5'd6:  w = uw(1'b1, SEL_A_DEN, SEL_B_NUM, OP_ACC_LD,   JMP_NEXT);
            5'd7:  w = uw(1'b1, SEL_A_DEN, SEL_B_DEN, OP_NUM_SUB,  JMP_NEXT);
            5'd8:  w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_DEN_LD,   JMP_NEXT);
            5'd9:  w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_DONE);
            // multiply: (an*bn) / (ad*bd)
            5'd10: w = uw(1'b1, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_NEXT);
            5'd11: w = uw(1'b1, SEL_A_DEN, SEL_B_DEN, OP_NUM_LD,   JMP_NEXT);
            5'd12: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_DEN_LD,   JMP_NEXT);
            5'd13: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_DONE);
            // divide: (an*bd) / (ad*bn)
            5'd14: w = uw(1'b1, SEL_A_NUM, SEL_B_DEN, OP_NOP,      JMP_NEXT);
            5'd15: w = uw(1'b1, SEL_A_DEN, SEL_B_NUM, OP_NUM_LD,   JMP_NEXT);
            5'd16: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_DEN_LD,   JMP_NEXT);
            5'd17: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_DONE);
            // scale: (an*s) / (ad*s)
            5'd18: w = uw(1'b1, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_NEXT);
            5'd19: w = uw(1'b1, SEL_A_DEN, SEL_B_NUM, OP_NUM_LD,   JMP_NEXT);
            5'd20: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_DEN_LD,   JMP_NEXT);
            5'd21: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_DONE);
            // classify
            5'd22: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_GCD_INIT, JMP_NEXT);
            5'd23: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_GCD_STEP, JMP_WAIT);
            5'd24: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_CLS_SET,  JMP_NEXT);
            5'd25: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,      JMP_DONE);
            // unused action codes
            5'd26: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_CLR,      JMP_NEXT);
            default: w = uw(1'b0, SEL_A_NUM, SEL_B_NUM, OP_NOP,    JMP_DONE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rfa_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
interface rfa_in_if import rfa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;

    modport source (output valid, output action, output a_num, output a_den,
                    output b_num, output b_den, input ready);
    modport sink   (input valid, input action, input a_num, input a_den,
                    input b_num, input b_den, output ready);
endinterface

interface rfa_out_if import rfa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] res_num;
    logic signed [WIDTH-1:0] res_den;
    logic [CLS_W-1:0]        class_code;

    modport source (output valid, output res_num, output res_den,
                    output class_code, input ready);
    modport sink   (input valid, input res_num, input res_den,
                    input class_code, output ready);
endinterface

// ===== rtl/rational_fraction_alu_unit.sv =====
// Top level of the rational fraction ALU: sequencer, datapath and result register.
//
//  Channel  Direction  Payload                               Transaction
//  req      sink       action, a_num, a_den, b_num, b_den    valid && ready
//  rsp      source     res_num, res_den, class_code          valid && ready
//
// One request is worked on at a time. Each action runs its microcode program from
// acceptance to its final step; unused action codes run a short program that clears
// the result, and classify also runs the binary GCD stepper until it is done, which
// halves after every subtraction.
// The result enters the output register at the final step, and the
// next request can be accepted in the cycle after that.
// The single shared multiplier and the one-step-per-cycle GCD loop set how long a
// request takes. A new request is taken as soon as the sequencer is idle, even while
// the previous result still waits in the output register; a stalled rsp holds
// the sequencer on its final step. Reset is asynchronous and active low and
// clears the sequencer and the output valid flag; there is no clearing pass.
module rational_fraction_alu_unit import rfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rfa_in_if.sink   req,
    rfa_out_if.source rsp
);

    dp_ctrl_t         ctrl;
    dp_stat_t         stat;
    logic             busy;
    logic             finish;
    logic             start;
    logic             out_free;
    logic [WIDTH-1:0] dp_num, dp_den;
    logic [CLS_W-1:0] dp_cls;

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_num_reg, out_den_reg;
    logic [CLS_W-1:0] out_cls_reg;

    // The sequencer is free exactly when it is not busy.
    assign req.ready = !busy;
    assign start     = req.valid && !busy;
    // The output register can take a new result when empty or being drained.
    assign out_free  = !out_valid_reg || rsp.ready;

    rfa_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (req.action),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .finish   (finish)
    );

    rfa_dp u_dp
    (
        .clk      (clk),
        .load     (start),
        .in_a_num (req.a_num),
        .in_a_den (req.a_den),
        .in_b_num (req.b_num),
        .in_b_den (req.b_den),
        .ctrl     (ctrl),
        .stat     (stat),
        .num      (dp_num),
        .den      (dp_den),
        .cls      (dp_cls)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload is captured when the sequencer retires a request.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_num_reg <= dp_num;
            out_den_reg <= dp_den;
            out_cls_reg <= dp_cls;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.res_num    = out_num_reg;
    assign rsp.res_den    = out_den_reg;
    assign rsp.class_code = out_cls_reg;

endmodule

// ===== rtl/rfa_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module rfa_seq import rfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACT_W-1:0] action,
    input  logic             out_free,
    input  dp_stat_t         stat,
    output dp_ctrl_t         ctrl,
    output logic             busy,
    output logic             finish
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      word;

    assign word = ucode_rom(pc_reg);

    assign ctrl.word    = word;
    assign ctrl.step_en = busy_reg && (word.jmp != JMP_DONE);
    assign busy         = busy_reg;
    assign finish       = busy_reg && (word.jmp == JMP_DONE) && out_free;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = entry_pc(action);
            end
        end
        else
        begin
            case (word.jmp)
                JMP_NEXT: pc_next = pc_reg + 1'b1;
                JMP_WAIT:
                begin
                    if (stat.gcd_done)
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                JMP_DONE:
                begin
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

// ===== rtl/rfa_dp.sv =====
// Datapath: operand registers, one multiplier, accumulator and a binary GCD stepper.
module rfa_dp import rfa_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic [WIDTH-1:0] in_a_num,
    input  logic [WIDTH-1:0] in_a_den,
    input  logic [WIDTH-1:0] in_b_num,
    input  logic [WIDTH-1:0] in_b_den,
    input  dp_ctrl_t         ctrl,
    output dp_stat_t         stat,
    output logic [WIDTH-1:0] num,
    output logic [WIDTH-1:0] den,
    output logic [CLS_W-1:0] cls
);

    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [WIDTH-1:0] prod_reg, acc_reg, num_reg, den_reg;
    logic [CLS_W-1:0] cls_reg;
    logic [WIDTH-1:0] x_reg, y_reg;
    logic             com_reg;

    logic [WIDTH-1:0] mul_a, mul_b, prod_next;
    logic [WIDTH-1:0] ad_abs, g_val;
    logic             a_ge2, gcd_done, gcd_ge2;

    assign mul_a     = (ctrl.word.a_sel == SEL_A_DEN) ? ad_reg : an_reg;
    assign mul_b     = (ctrl.word.b_sel == SEL_B_DEN) ? bd_reg : bn_reg;
    assign prod_next = mul_a * mul_b;

    assign ad_abs   = ad_reg[WIDTH-1] ? (~ad_reg + 1'b1) : ad_reg;
    assign a_ge2    = !an_reg[WIDTH-1] && (an_reg >= WIDTH'(2));
    assign gcd_done = (x_reg == '0) || (y_reg == '0) || com_reg;
    // Once one side reaches zero the other side is the (odd part of the) divisor.
    assign g_val    = x_reg | y_reg;
    assign gcd_ge2  = com_reg || (g_val >= WIDTH'(2));

    assign stat.gcd_done = gcd_done;
    assign num = num_reg;
    assign den = den_reg;
    assign cls = cls_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            an_reg <= in_a_num;
            ad_reg <= in_a_den;
            bn_reg <= in_b_num;
            bd_reg <= in_b_den;
        end
        if (ctrl.step_en)
        begin
            if (ctrl.word.mul_en)
            begin
                prod_reg <= prod_next;
            end
            case (ctrl.word.op)
                OP_NOP: ;
                OP_ACC_LD: acc_reg <= prod_reg;
                OP_NUM_LD:
                begin
                    num_reg <= prod_reg;
                    cls_reg <= '0;
                end
                OP_NUM_ADD:
                begin
                    num_reg <= acc_reg + prod_reg;
                    cls_reg <= '0;
                end
                OP_NUM_SUB:
                begin
                    num_reg <= acc_reg - prod_reg;
                    cls_reg <= '0;
                end
                OP_DEN_LD: den_reg <= prod_reg;
                OP_CLR:
                begin
                    num_reg <= '0;
                    den_reg <= '0;
                    cls_reg <= '0;
                end
                OP_GCD_INIT:
                begin
                    com_reg <= 1'b0;
                    if (a_ge2)
                    begin
                        x_reg <= an_reg;
                        y_reg <= ad_abs;
                    end
                    else
                    begin
                        x_reg <= '0;
                        y_reg <= '0;
                    end
                end
                OP_GCD_STEP:
                begin
                    if (!gcd_done)
                    begin
                        if (!x_reg[0] && !y_reg[0])
                        begin
                            com_reg <= 1'b1;
                        end
                        else if (!x_reg[0])
                        begin
                            x_reg <= x_reg >> 1;
                        end
                        else if (!y_reg[0])
                        begin
                            y_reg <= y_reg >> 1;
                        end
                        else if (x_reg >= y_reg)
                        begin
                            x_reg <= x_reg - y_reg;
                        end
                        else
                        begin
                            y_reg <= y_reg - x_reg;
                        end
                    end
                end
                OP_CLS_SET:
                begin
                    num_reg <= '0;
                    den_reg <= '0;
                    if (gcd_ge2)
                    begin
                        cls_reg <= CLS_SIMPLIFIABLE;
                    end
                    else if (ad_reg == WIDTH'(1))
                    begin
                        cls_reg <= CLS_INTEGER;
                    end
                    else if ((an_reg != '0) && (ad_reg != '0))
                    begin
                        cls_reg <= CLS_PROPER;
                    end
                    else if (an_reg == '0)
                    begin
                        cls_reg <= CLS_ZERO;
                    end
                    else
                    begin
                        cls_reg <= CLS_DIV_ZERO;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== verif/rational_fraction_alu_unit_tb.sv =====
// Self-checking testbench for the rational fraction ALU: directed and random requests.
module rational_fraction_alu_unit_tb;
    import rfa_pkg::*;

    // Action codes that the unit does not define; it answers them with an all-zero result.
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam logic signed [WIDTH-1:0] S_MAX = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic signed [WIDTH-1:0] S_MIN = {1'b1, {(WIDTH-1){1'b0}}};

    // Number of random requests after the directed ones.
    localparam int RANDOM_REQS = 650;
    // Length of each long receiver hold-off, in cycles.
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [WIDTH-1:0] a_num;
        logic signed [WIDTH-1:0] a_den;
        logic signed [WIDTH-1:0] b_num;
        logic signed [WIDTH-1:0] b_den;
    } fraction_req_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] num;
        logic signed [WIDTH-1:0] den;
        logic [CLS_W-1:0]        cls;
    } fraction_res_t;

    logic clk;
    logic rst_n;

    rfa_in_if  req_ch ();
    rfa_out_if rsp_ch ();

    rational_fraction_alu_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests not yet accepted by the unit; the front one is the one on offer.
    fraction_req_t pending_reqs[$];
    // Results owed by the unit, oldest first.
    fraction_res_t awaited_results[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    // Set by the monitor at each rising edge when a request transaction took place.
    bit  req_taken      = 1'b0;

    // Sender pacing state.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pacing state.
    int rx_cycle        = 0;
    int rx_mode         = 0;
    int holdoff_left    = 0;
    int holdoffs_done   = 0;
    int next_holdoff_at = 120;

    // Print category of a fraction. The common-divisor test uses the magnitude of the
    // denominator, so a zero denominator divides everything and any numerator of at
    // least two over it is simplifiable.
    function automatic logic [CLS_W-1:0] print_category(input logic signed [WIDTH-1:0] n,
                                                       input logic signed [WIDTH-1:0] d);
        longint          d_wide;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        d_wide = longint'(d);
        if (n >= 2)
        begin
            x = longint'(n);
            y = (d_wide < 0) ? -d_wide : d_wide;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            if (x >= 2)
                return CLS_SIMPLIFIABLE;
        end
        if (d == 1)
            return CLS_INTEGER;
        if (n != 0 && d != 0)
            return CLS_PROPER;
        if (n == 0)
            return CLS_ZERO;
        return CLS_DIV_ZERO;
    endfunction

    // Cross-multiplied result of one request. All products and sums are taken at the
    // datapath width, so they wrap exactly as the hardware does.
    function automatic fraction_res_t fraction_result(input fraction_req_t q);
        fraction_res_t r;
        r = '0;
        case (q.action)
            ACT_ADD:
            begin
                r.num = q.a_num * q.b_den + q.a_den * q.b_num;
                r.den = q.a_den * q.b_den;
            end
            ACT_SUB:
            begin
                r.num = q.a_num * q.b_den - q.a_den * q.b_num;
                r.den = q.a_den * q.b_den;
            end
            ACT_MUL:
            begin
                r.num = q.a_num * q.b_num;
                r.den = q.a_den * q.b_den;
            end
            ACT_DIV:
            begin
                r.num = q.a_num * q.b_den;
                r.den = q.a_den * q.b_num;
            end
            ACT_SCALE:
            begin
                r.num = q.a_num * q.b_num;
                r.den = q.a_den * q.b_num;
            end
            ACT_CLASSIFY:
                r.cls = print_category(q.a_num, q.a_den);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic queue_req(input logic [ACT_W-1:0] action,
                             input logic signed [WIDTH-1:0] a_num,
                             input logic signed [WIDTH-1:0] a_den,
                             input logic signed [WIDTH-1:0] b_num,
                             input logic signed [WIDTH-1:0] b_den);
        fraction_req_t q;
        q.action = action;
        q.a_num  = a_num;
        q.a_den  = a_den;
        q.b_num  = b_num;
        q.b_den  = b_den;
        pending_reqs.push_back(q);
    endtask

    // Operand for the arithmetic actions: a mix of full-range words, small values,
    // the extremes and mid-sized values.
    function automatic logic signed [WIDTH-1:0] random_operand();
        logic signed [WIDTH-1:0] v;
        case ($urandom_range(0, 5))
            0, 1, 5: v = $urandom;
            2:       v = $signed($urandom_range(0, 40)) - 20;
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       v = S_MIN;
                    1:       v = S_MAX;
                    2:       v = -1;
                    3:       v = 0;
                    default: v = 1;
                endcase
            end
            default: v = $signed($urandom_range(0, 65535)) - 32768;
        endcase
        return v;
    endfunction

    task automatic queue_random_classify();
        logic signed [WIDTH-1:0] n;
        logic signed [WIDTH-1:0] d;
        int k;
        k = $urandom_range(2, 60);
        case ($urandom_range(0, 7))
            // A shared factor, denominator of either sign.
            0, 1:
            begin
                n = k * $urandom_range(1, 2000);
                d = k * $urandom_range(1, 2000);
                if ($urandom_range(0, 1))
                    d = -d;
            end
            // Negative numerator with a shared factor stays a proper fraction.
            2:
            begin
                n = -(k * $urandom_range(1, 2000));
                d = k * $urandom_range(1, 2000);
            end
            3:
            begin
                n = random_operand();
                d = 1;
            end
            4:
            begin
                n = random_operand();
                d = 0;
            end
            5:
            begin
                n = 0;
                d = random_operand();
            end
            6:
            begin
                n = $urandom_range(0, 200);
                d = $signed($urandom_range(0, 400)) - 200;
            end
            default:
            begin
                n = $urandom;
                d = $urandom;
            end
        endcase
        queue_req(ACT_CLASSIFY, n, d, $urandom, $urandom);
    endtask

    task automatic report_field(input string field, input longint expv, input longint gotv);
        if (expv != gotv)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, gotv);
        end
    endtask

    // Clock with a period of 10 time units.
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Every input of the unit has a known value from time zero.
    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_ADD;
        req_ch.a_num      = '0;
        req_ch.a_den      = '0;
        req_ch.b_num      = '0;
        req_ch.b_den      = '0;
        rsp_ch.ready      = 1'b0;
    end

    // Sender. It offers requests in bursts with gaps between them. Once valid is raised
    // it stays up with the same payload until the transaction has taken place.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (req_ch.valid && !req_taken)
            req_ch.valid <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left--;
            req_ch.valid <= 1'b0;
        end
        else if (pending_reqs.size() == 0)
            req_ch.valid <= 1'b0;
        else
        begin
            req_ch.valid  <= 1'b1;
            req_ch.action <= pending_reqs[0].action;
            req_ch.a_num  <= pending_reqs[0].a_num;
            req_ch.a_den  <= pending_reqs[0].a_den;
            req_ch.b_num  <= pending_reqs[0].b_num;
            req_ch.b_den  <= pending_reqs[0].b_den;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                // One burst in four runs back to back with no gap after it, and one
                // in eight is long, so there are stretches without any idling.
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
            end
        end
    end

    // Receiver. It redraws its stall pattern periodically. Twice during the run it holds
    // off for a long stretch while the sender keeps offering, so that the result register
    // and the sequencer both fill and the request side stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (rx_cycle % 50 == 0)
                rx_mode = $urandom_range(0, 3);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (holdoffs_done < 2 && results_seen >= next_holdoff_at)
            begin
                holdoffs_done++;
                next_holdoff_at += 250;
                holdoff_left = HOLDOFF_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= (rx_cycle % 7) < 4;
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor. It samples both channels at the rising edge: an accepted request adds its
    // expected result to the back of the queue, and an accepted result is checked against
    // the front of it.
    always @(posedge clk)
    begin
        fraction_res_t expected;
        fraction_req_t taken;
        req_taken = rst_n && req_ch.valid && req_ch.ready;
        if (req_taken)
        begin
            taken.action = req_ch.action;
            taken.a_num  = req_ch.a_num;
            taken.a_den  = req_ch.a_den;
            taken.b_num  = req_ch.b_num;
            taken.b_den  = req_ch.b_den;
            awaited_results.push_back(fraction_result(taken));
            if (pending_reqs.size() != 0)
                void'(pending_reqs.pop_front());
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d class %0d",
                         $time, rsp_ch.res_num, rsp_ch.res_den, rsp_ch.class_code);
            end
            else
            begin
                expected = awaited_results.pop_front();
                report_field("res_num", expected.num, rsp_ch.res_num);
                report_field("res_den", expected.den, rsp_ch.res_den);
                report_field("class_code", expected.cls, rsp_ch.class_code);
            end
        end
    end

    // Stimulus and end of test.
    initial
    begin
        // Arithmetic at the extremes, including overflow and zero divisors.
        queue_req(ACT_ADD, 1, 2, 1, 3);
        queue_req(ACT_ADD, S_MAX, 1, 1, 1);
        queue_req(ACT_SUB, S_MIN, 1, 1, 1);
        queue_req(ACT_SUB, -1, -1, S_MAX, S_MIN);
        queue_req(ACT_MUL, S_MAX, S_MAX, S_MAX, S_MAX);
        queue_req(ACT_MUL, S_MIN, -1, -1, S_MIN);
        queue_req(ACT_DIV, 3, 4, 0, 5);
        queue_req(ACT_DIV, -7, 3, S_MIN, S_MAX);
        queue_req(ACT_SCALE, 5, 7, 0, S_MAX);
        queue_req(ACT_SCALE, S_MIN, 3, -1, S_MIN);
        // Classification: simplifiable, also over a zero or negative denominator.
        queue_req(ACT_CLASSIFY, 6, 4, 0, 0);
        queue_req(ACT_CLASSIFY, 4, 0, 0, 0);
        queue_req(ACT_CLASSIFY, 6, -4, 0, 0);
        queue_req(ACT_CLASSIFY, 4, S_MIN, 0, 0);
        // Integers, including a numerator below two and a negative one.
        queue_req(ACT_CLASSIFY, 5, 1, 0, 0);
        queue_req(ACT_CLASSIFY, 1, 1, 0, 0);
        queue_req(ACT_CLASSIFY, -6, 1, 0, 0);
        // Proper fractions; a negative numerator never counts as simplifiable.
        queue_req(ACT_CLASSIFY, 3, 4, 0, 0);
        queue_req(ACT_CLASSIFY, -6, 4, 0, 0);
        queue_req(ACT_CLASSIFY, S_MAX, S_MIN, 0, 0);
        // Zero, with zero over zero among them, and divide by zero.
        queue_req(ACT_CLASSIFY, 0, 5, 0, 0);
        queue_req(ACT_CLASSIFY, 0, 0, 0, 0);
        queue_req(ACT_CLASSIFY, 1, 0, 0, 0);
        queue_req(ACT_CLASSIFY, S_MIN, 0, 0, 0);
        // The two undefined action codes.
        queue_req(ACT_SPARE_6, -1, -1, -1, -1);
        queue_req(ACT_SPARE_7, S_MIN, S_MAX, S_MIN, S_MAX);

        // Random part: roughly a third classify requests, a few undefined codes, and
        // the rest arithmetic on mixed operands.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                queue_random_classify();
            else if (pick < 40)
                queue_req(ACT_W'($urandom_range(ACT_SPARE_6, ACT_SPARE_7)), $urandom,
                          $urandom, $urandom, $urandom);
            else
                queue_req(ACT_W'($urandom_range(ACT_ADD, ACT_SCALE)), random_operand(),
                          random_operand(), random_operand(), random_operand());
        end

        // Reset is held low from time zero and released at a falling edge.
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        // Once both queues are empty, any result that still shows up is extra.
        repeat (200)
            @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("[rational_fraction_alu_unit] OK");
        else
            $display("[rational_fraction_alu_unit] ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #10000000;
        $display("[rational_fraction_alu_unit] ERROR");
        $finish;
    end

endmodule
